// ===== rtl/core/raid_stripe_sector_mapper_defines.svh =====
// ----------------------------------------------------------------------------
// raid_stripe_sector_mapper_defines
// Assertion macros shared by the sector mapper RTL.
// ----------------------------------------------------------------------------
// All checks run on clk_i and are off while rst_ni is low.
`ifndef RAID_STRIPE_SECTOR_MAPPER_DEFINES_SVH
`define RAID_STRIPE_SECTOR_MAPPER_DEFINES_SVH

// Property check, clocked on clk_i, disabled in reset.
`define RSSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must hold in every cycle in which the guard is true.
`define RSSM_ASSERT_IF(lbl, guard, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (guard) |-> (cond)) \
    else $error(msg);

`endif

// ===== rtl/core/rssm_pkg.sv =====
// ----------------------------------------------------------------------------
// rssm_pkg
// Types and constants of the RAID 4/5/6 sector mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package rssm_pkg;

  localparam int SECTOR_BITS = 48;
  localparam int HALF_BITS   = SECTOR_BITS / 2;
  localparam int MAX_DISKS   = 64;
  localparam int CS_W        = 21;
  localparam int DISK_W      = 7;
  localparam int DIDX_W      = 6;
  localparam int LVL_W       = 4;
  localparam int RED_W       = 2;
  localparam int IDX_W       = 3;
  localparam int MATH_W      = 9;

  localparam logic [LVL_W-1:0] LEVEL_4 = 4'd4;
  localparam logic [LVL_W-1:0] LEVEL_5 = 4'd5;
  localparam logic [LVL_W-1:0] LEVEL_6 = 4'd6;

  typedef enum logic [3:0] {
    LAY_LEFT_ASYM    = 4'd0,
    LAY_RIGHT_ASYM   = 4'd1,
    LAY_LEFT_SYM     = 4'd2,
    LAY_RIGHT_SYM    = 4'd3,
    LAY_PARITY_0     = 4'd4,
    LAY_PARITY_N     = 4'd5,
    LAY_ROT_ZERO_RST = 4'd6,
    LAY_ROT_N_RST    = 4'd7,
    LAY_ROT_N_CONT   = 4'd8,
    LAY_LEFT_ASYM_6  = 4'd9,
    LAY_RIGHT_ASYM_6 = 4'd10,
    LAY_LEFT_SYM_6   = 4'd11,
    LAY_RIGHT_SYM_6  = 4'd12,
    LAY_PARITY_0_6   = 4'd13
  } layout_e;

  typedef enum logic [IDX_W-1:0] {
    REG_RAID_LEVEL     = 3'd0,
    REG_LAYOUT         = 3'd1,
    REG_CHUNK_SIZE     = 3'd2,
    REG_DISK_COUNT     = 3'd3,
    REG_REDUNDANCY     = 3'd4,
    REG_OLD_LAYOUT     = 3'd5,
    REG_OLD_CHUNK_SIZE = 3'd6,
    REG_OLD_DISK_COUNT = 3'd7
  } reg_idx_e;

  // Sideband that travels down the pipe with each item
  typedef struct packed {
    logic                   bad;
    logic [LVL_W-1:0]       level;
    logic [3:0]             alg;
    logic [CS_W-1:0]        cs;
    logic [DISK_W-1:0]      rd;
    logic [DISK_W-1:0]      dd;
    logic [CS_W-1:0]        offset;
    logic [DIDX_W-1:0]      di;
    logic [SECTOR_BITS-1:0] stripe;
    logic [DISK_W-1:0]      m_rd;
    logic [DISK_W-1:0]      m_rd1;
  } meta_t;

endpackage

`default_nettype wire

// ===== rtl/core/rssm_if.sv =====
// ----------------------------------------------------------------------------
// rssm_in_if / rssm_out_if
// Valid/ready channels of the sector mapper.
// ----------------------------------------------------------------------------
`default_nettype none

interface rssm_in_if;
  logic                            valid;
  logic                            ready;
  logic [rssm_pkg::SECTOR_BITS-1:0] array_sector;
  logic                            use_old;

  modport source (output valid, array_sector, use_old, input ready);
  modport sink   (input valid, array_sector, use_old, output ready);
endinterface

interface rssm_out_if;
  logic                             valid;
  logic                             ready;
  logic [rssm_pkg::SECTOR_BITS-1:0] disk_sector;
  logic [rssm_pkg::DIDX_W-1:0]      data_disk;
  logic signed [rssm_pkg::DISK_W-1:0] parity_disk;
  logic signed [rssm_pkg::DISK_W-1:0] q_parity_disk;
  logic                             bad_layout;

  modport source (output valid, disk_sector, data_disk, parity_disk, q_parity_disk,
                  bad_layout, input ready);
  modport sink   (input valid, disk_sector, data_disk, parity_disk, q_parity_disk,
                  bad_layout, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/raid_stripe_sector_mapper.sv =====
// ----------------------------------------------------------------------------
// raid_stripe_sector_mapper
// Maps an array sector to member disk, disk sector, P and Q disks (RAID 4/5/6).
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// in_i      in   array_sector[47:0], use_old
// out_o     out  disk_sector[47:0], data_disk[5:0], parity_disk, q_parity_disk,
//                bad_layout
// cfg_*     in   cfg_idx_i[2:0], cfg_data_i[20:0], cfg_we_i
//
// One item per cycle; the pipe is one entry stage, four 48-stage
// dividers (sector by chunk, chunk by data disks, stripe by disks and by
// disks minus one), one placement/multiply stage and the output register.
// in_i.ready drops only when the output register holds an untaken item; the
// whole pipe then freezes. Reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "raid_stripe_sector_mapper_defines.svh"

module raid_stripe_sector_mapper (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [rssm_pkg::IDX_W-1:0] cfg_idx_i,
  input  wire logic [rssm_pkg::CS_W-1:0]  cfg_data_i,
  rssm_in_if.sink                         in_i,
  rssm_out_if.source                      out_o
);
  import rssm_pkg::*;

  logic en;
  logic vld_e, vld_a, vld_b, vld_c, vld_d;
  logic [SECTOR_BITS-1:0] sector_e, quot_a, quot_b, quot_c, quot_d;
  logic [CS_W-1:0] rem_a, rem_b, rem_c, rem_d;
  meta_t meta_e, meta_a, meta_b, meta_c, meta_d;
  meta_t meta_a_in, meta_b_in, meta_c_in, meta_d_in;
  meta_t meta_p;

  // Whole pipe advances unless a finished item waits
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  rssm_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .en_i      (en),
    .vld_i     (in_i.valid),
    .sector_i  (in_i.array_sector),
    .use_old_i (in_i.use_old),
    .vld_o     (vld_e),
    .sector_o  (sector_e),
    .meta_o    (meta_e)
  );

  // Sector / chunk size
  assign meta_a_in = meta_e;
  rssm_div u_div_chunk (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(vld_e), .dividend_i(sector_e), .divisor_i(meta_e.cs), .meta_i(meta_a_in),
    .vld_o(vld_a), .quot_o(quot_a), .rem_o(rem_a), .meta_o(meta_a)
  );

  // Chunk / data disks
  always_comb begin
    meta_b_in        = meta_a;
    meta_b_in.offset = rem_a;
  end
  rssm_div u_div_stripe (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(vld_a), .dividend_i(quot_a), .divisor_i(CS_W'(meta_a.dd)), .meta_i(meta_b_in),
    .vld_o(vld_b), .quot_o(quot_b), .rem_o(rem_b), .meta_o(meta_b)
  );

  // Stripe mod disks
  always_comb begin
    meta_c_in        = meta_b;
    meta_c_in.stripe = quot_b;
    meta_c_in.di     = rem_b[DIDX_W-1:0];
  end
  rssm_div u_div_rot (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(vld_b), .dividend_i(quot_b), .divisor_i(CS_W'(meta_b.rd)), .meta_i(meta_c_in),
    .vld_o(vld_c), .quot_o(quot_c), .rem_o(rem_c), .meta_o(meta_c)
  );

  // Stripe mod (disks - 1) for the _6 layouts
  always_comb begin
    meta_d_in      = meta_c;
    meta_d_in.m_rd = rem_c[DISK_W-1:0];
  end
  rssm_div u_div_rot6 (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(vld_c), .dividend_i(meta_c.stripe),
    .divisor_i(CS_W'(meta_c.rd - DISK_W'(1))), .meta_i(meta_d_in),
    .vld_o(vld_d), .quot_o(quot_d), .rem_o(rem_d), .meta_o(meta_d)
  );

  always_comb begin
    meta_p       = meta_d;
    meta_p.m_rd1 = rem_d[DISK_W-1:0];
    if (quot_c != quot_d) meta_p.m_rd1 = rem_d[DISK_W-1:0];
  end

  rssm_place u_place (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(vld_d), .meta_i(meta_p), .out_o
  );

  // A bad mapping carries the fixed error result
  `RSSM_ASSERT_IF(a_bad_result, out_o.valid && out_o.bad_layout,
                  (out_o.disk_sector == '0) && (out_o.data_disk == '0)
                  && (out_o.parity_disk == -7'sd1) && (out_o.q_parity_disk == -7'sd1),
                  "bad mapping result not cleared")
  // A waiting result blocks the input
  `RSSM_ASSERT_IF(a_in_blocked, out_o.valid && !out_o.ready, !in_i.ready,
                  "input taken while a result waits")
  // A waiting result stays put until taken
  `RSSM_ASSERT(a_out_hold, (out_o.valid && !out_o.ready) |=>
               (out_o.valid && $stable(out_o.disk_sector) && $stable(out_o.data_disk)
                && $stable(out_o.parity_disk) && $stable(out_o.q_parity_disk)
                && $stable(out_o.bad_layout)),
               "waiting result changed")

endmodule

`default_nettype wire

// ===== rtl/core/rssm_cfg.sv =====
// ----------------------------------------------------------------------------
// rssm_cfg
// Configuration registers and the entry stage: geometry select and checks.
// ----------------------------------------------------------------------------
`default_nettype none

module rssm_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [rssm_pkg::IDX_W-1:0]       cfg_idx_i,
  input  wire logic [rssm_pkg::CS_W-1:0]        cfg_data_i,
  input  wire logic                             en_i,
  input  wire logic                             vld_i,
  input  wire logic [rssm_pkg::SECTOR_BITS-1:0] sector_i,
  input  wire logic                             use_old_i,
  output logic                                  vld_o,
  output logic [rssm_pkg::SECTOR_BITS-1:0]      sector_o,
  output rssm_pkg::meta_t                       meta_o
);
  import rssm_pkg::*;

  logic [LVL_W-1:0]  level_q;
  logic [3:0]        layout_q, old_layout_q;
  logic [CS_W-1:0]   chunk_q, old_chunk_q;
  logic [DISK_W-1:0] disks_q, old_disks_q;
  logic [RED_W-1:0]  red_q;

  logic              vld_q;
  logic [SECTOR_BITS-1:0] sector_q;
  meta_t             meta_q, meta_d;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q      <= LEVEL_5;
      layout_q     <= LAY_LEFT_SYM;
      chunk_q      <= CS_W'(128);
      disks_q      <= DISK_W'(4);
      red_q        <= RED_W'(1);
      old_layout_q <= LAY_LEFT_SYM;
      old_chunk_q  <= CS_W'(128);
      old_disks_q  <= DISK_W'(4);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_RAID_LEVEL:     level_q      <= cfg_data_i[LVL_W-1:0];
        REG_LAYOUT:         layout_q     <= cfg_data_i[3:0];
        REG_CHUNK_SIZE:     chunk_q      <= cfg_data_i;
        REG_DISK_COUNT:     disks_q      <= cfg_data_i[DISK_W-1:0];
        REG_REDUNDANCY:     red_q        <= cfg_data_i[RED_W-1:0];
        REG_OLD_LAYOUT:     old_layout_q <= cfg_data_i[3:0];
        REG_OLD_CHUNK_SIZE: old_chunk_q  <= cfg_data_i;
        REG_OLD_DISK_COUNT: old_disks_q  <= cfg_data_i[DISK_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry select and sanity checks
  always_comb begin
    logic [DISK_W-1:0] rd;
    logic [3:0]        alg;
    logic              geo_bad;
    logic              lay_bad;
    rd  = use_old_i ? old_disks_q : disks_q;
    alg = use_old_i ? old_layout_q : layout_q;
    meta_d        = '0;
    meta_d.level  = level_q;
    meta_d.alg    = alg;
    meta_d.cs     = use_old_i ? old_chunk_q : chunk_q;
    meta_d.rd     = rd;
    meta_d.dd     = rd - DISK_W'(red_q);
    geo_bad = (meta_d.cs == '0) || (rd == '0) || (rd > DISK_W'(MAX_DISKS))
           || (red_q > RED_W'(2)) || (rd <= DISK_W'(red_q));
    lay_bad = ((level_q == LEVEL_5) && (alg > LAY_PARITY_N))
           || ((level_q == LEVEL_6) && (alg > LAY_PARITY_0_6))
           || ((level_q == LEVEL_6) && (alg >= LAY_LEFT_ASYM_6)
               && (alg <= LAY_PARITY_0_6) && (rd < DISK_W'(2)));
    meta_d.bad = geo_bad || lay_bad;
  end

  // Entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sector_q <= sector_i;
      meta_q   <= meta_d;
    end
  end

  assign vld_o    = vld_q;
  assign sector_o = sector_q;
  assign meta_o   = meta_q;

endmodule

`default_nettype wire

// ===== rtl/core/rssm_div.sv =====
// ----------------------------------------------------------------------------
// rssm_div
// Pipelined restoring divider: one quotient bit per stage, sideband alongside.
// ----------------------------------------------------------------------------
`default_nettype none

`include "raid_stripe_sector_mapper_defines.svh"

module rssm_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic                             vld_i,
  input  wire logic [rssm_pkg::SECTOR_BITS-1:0] dividend_i,
  input  wire logic [rssm_pkg::CS_W-1:0]        divisor_i,
  input  wire rssm_pkg::meta_t                  meta_i,
  output logic                                  vld_o,
  output logic [rssm_pkg::SECTOR_BITS-1:0]      quot_o,
  output logic [rssm_pkg::CS_W-1:0]             rem_o,
  output rssm_pkg::meta_t                       meta_o
);
  import rssm_pkg::*;

  localparam int NSTG = SECTOR_BITS;

  logic [NSTG-1:0]        vld_q;
  logic [CS_W-1:0]        rem_q [NSTG];
  logic [SECTOR_BITS-1:0] dvd_q [NSTG];
  logic [CS_W-1:0]        dvs_q [NSTG];
  meta_t                  meta_q [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic [CS_W-1:0]        src_rem, rem_d;
    logic [SECTOR_BITS-1:0] src_dvd;
    logic [CS_W-1:0]        src_dvs;
    meta_t                  src_meta;
    logic                   src_vld;
    logic [CS_W:0]          trial;
    logic                   ge;

    if (k == 0) begin : g_first
      assign src_rem  = '0;
      assign src_dvd  = dividend_i;
      assign src_dvs  = divisor_i;
      assign src_meta = meta_i;
      assign src_vld  = vld_i;
    end else begin : g_next
      assign src_rem  = rem_q[k-1];
      assign src_dvd  = dvd_q[k-1];
      assign src_dvs  = dvs_q[k-1];
      assign src_meta = meta_q[k-1];
      assign src_vld  = vld_q[k-1];
    end

    // Shift in the next dividend bit, subtract if it fits
    assign trial = {src_rem, src_dvd[SECTOR_BITS-1]};
    assign ge    = (trial >= {1'b0, src_dvs});
    assign rem_d = ge ? CS_W'(trial - {1'b0, src_dvs}) : CS_W'(trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        dvd_q[k]  <= {src_dvd[SECTOR_BITS-2:0], ge};
        dvs_q[k]  <= src_dvs;
        meta_q[k] <= src_meta;
      end
    end
  end

  assign vld_o  = vld_q[NSTG-1];
  assign quot_o = dvd_q[NSTG-1];
  assign rem_o  = rem_q[NSTG-1];
  assign meta_o = meta_q[NSTG-1];

  // A stalled pipe keeps every valid bit; a moving one shifts them by one
  `RSSM_ASSERT(a_div_stall_hold, !en_i |=> $stable(vld_q),
               "divider valid moved in stall")
  `RSSM_ASSERT(a_div_shift, en_i |=> (vld_q[NSTG-1:1] == $past(vld_q[NSTG-2:0])),
               "divider valid lost")
  `RSSM_ASSERT(a_div_enter, en_i |=> (vld_q[0] == $past(vld_i)),
               "divider input valid lost")

endmodule

`default_nettype wire

// ===== rtl/core/rssm_place.sv =====
// ----------------------------------------------------------------------------
// rssm_place
// Parity and data disk placement per layout, disk sector product, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module rssm_place (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             vld_i,
  input  wire rssm_pkg::meta_t  meta_i,
  rssm_out_if.source            out_o
);
  import rssm_pkg::*;

  typedef logic signed [MATH_W-1:0] sv_t;

  localparam sv_t S_ZERO = sv_t'(0);
  localparam sv_t S_ONE  = sv_t'(1);
  localparam sv_t S_TWO  = sv_t'(2);
  localparam sv_t S_NONE = sv_t'(-1);

  // Small modulo for non-negative values under five times the divisor
  function automatic sv_t mod_small(input sv_t v, input sv_t d);
    sv_t r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (r >= d) r = r - d;
    end
    return r;
  endfunction

  logic                   f1_vld_q;
  logic                   f1_bad_q;
  logic [HALF_BITS+CS_W-1:0] plo_q, phi_q;
  logic [CS_W-1:0]        off_q;
  sv_t                    di_q, pd_q, qd_q;
  sv_t                    di_d, pd_d, qd_d;

  logic                   vld_q;
  logic [SECTOR_BITS-1:0] sec_q;
  logic [DIDX_W-1:0]      ddisk_q;
  logic [DISK_W-1:0]      pdisk_q, qdisk_q;
  logic                   bad_q;

  // Layout placement
  always_comb begin
    sv_t rd, dd, m, m7, m1, di, s;
    rd = sv_t'(meta_i.rd);
    dd = sv_t'(meta_i.dd);
    m  = sv_t'(meta_i.m_rd);
    m1 = sv_t'(meta_i.m_rd1);
    di = sv_t'(meta_i.di);
    m7 = ((m + S_ONE) == rd) ? S_ZERO : m + S_ONE;
    s  = m;
    pd_d = S_NONE;
    qd_d = S_NONE;
    di_d = di;
    unique case (meta_i.level)
      LEVEL_4: pd_d = dd;
      LEVEL_5: begin
        unique case (layout_e'(meta_i.alg))
          LAY_LEFT_ASYM: begin
            pd_d = dd - m;
            if (di >= pd_d) di_d = di + S_ONE;
          end
          LAY_RIGHT_ASYM: begin
            pd_d = m;
            if (di >= pd_d) di_d = di + S_ONE;
          end
          LAY_LEFT_SYM: begin
            pd_d = dd - m;
            di_d = mod_small(pd_d + S_ONE + di, rd);
          end
          LAY_RIGHT_SYM: begin
            pd_d = m;
            di_d = mod_small(pd_d + S_ONE + di, rd);
          end
          LAY_PARITY_0: begin
            pd_d = S_ZERO;
            di_d = di + S_ONE;
          end
          LAY_PARITY_N: pd_d = dd;
          default: ;
        endcase
      end
      LEVEL_6: begin
        unique case (layout_e'(meta_i.alg))
          LAY_LEFT_ASYM, LAY_RIGHT_ASYM, LAY_ROT_ZERO_RST, LAY_ROT_N_RST: begin
            s = (meta_i.alg == LAY_ROT_N_RST) ? m7 : m;
            pd_d = ((meta_i.alg == LAY_LEFT_ASYM) || (meta_i.alg == LAY_ROT_N_RST))
                   ? rd - S_ONE - s : s;
            qd_d = pd_d + S_ONE;
            if (pd_d == rd - S_ONE) begin
              di_d = di + S_ONE;
              qd_d = S_ZERO;
            end else if (di >= pd_d) begin
              di_d = di + S_TWO;
            end
          end
          LAY_LEFT_SYM, LAY_RIGHT_SYM: begin
            pd_d = (meta_i.alg == LAY_LEFT_SYM) ? rd - S_ONE - m : m;
            qd_d = mod_small(pd_d + S_ONE, rd);
            di_d = mod_small(pd_d + S_TWO + di, rd);
          end
          LAY_PARITY_0: begin
            pd_d = S_ZERO;
            qd_d = S_ONE;
            di_d = di + S_TWO;
          end
          LAY_PARITY_N: begin
            pd_d = dd;
            qd_d = dd + S_ONE;
          end
          LAY_ROT_N_CONT: begin
            pd_d = rd - S_ONE - m;
            qd_d = mod_small(pd_d + rd - S_ONE, rd);
            di_d = mod_small(pd_d + S_ONE + di, rd);
          end
          LAY_LEFT_ASYM_6, LAY_RIGHT_ASYM_6: begin
            pd_d = (meta_i.alg == LAY_LEFT_ASYM_6) ? dd - m1 : m1;
            if (di >= pd_d) di_d = di + S_ONE;
            qd_d = rd - S_ONE;
          end
          LAY_LEFT_SYM_6, LAY_RIGHT_SYM_6: begin
            pd_d = (meta_i.alg == LAY_LEFT_SYM_6) ? dd - m1 : m1;
            di_d = mod_small(pd_d + S_ONE + di, rd - S_ONE);
            qd_d = rd - S_ONE;
          end
          LAY_PARITY_0_6: begin
            pd_d = S_ZERO;
            di_d = di + S_ONE;
            qd_d = rd - S_ONE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Placement stage and split product of stripe times chunk size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (en_i) begin
      f1_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_bad_q <= meta_i.bad;
      plo_q    <= meta_i.stripe[HALF_BITS-1:0] * meta_i.cs;
      phi_q    <= meta_i.stripe[SECTOR_BITS-1:HALF_BITS] * meta_i.cs;
      off_q    <= meta_i.offset;
      di_q     <= di_d;
      pd_q     <= pd_d;
      qd_q     <= qd_d;
    end
  end

  // Output register: sum of partial products, bad results forced
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bad_q <= f1_bad_q;
      if (f1_bad_q) begin
        sec_q   <= '0;
        ddisk_q <= '0;
        pdisk_q <= '1;
        qdisk_q <= '1;
      end else begin
        sec_q   <= SECTOR_BITS'(plo_q) + {phi_q[HALF_BITS-1:0], {HALF_BITS{1'b0}}}
                 + SECTOR_BITS'(off_q);
        ddisk_q <= di_q[DIDX_W-1:0];
        pdisk_q <= pd_q[DISK_W-1:0];
        qdisk_q <= qd_q[DISK_W-1:0];
      end
    end
  end

  assign out_o.valid         = vld_q;
  assign out_o.disk_sector   = sec_q;
  assign out_o.data_disk     = ddisk_q;
  assign out_o.parity_disk   = pdisk_q;
  assign out_o.q_parity_disk = qdisk_q;
  assign out_o.bad_layout    = bad_q;

endmodule

`default_nettype wire

// ===== bench/raid_stripe_sector_mapper_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// raid_stripe_sector_mapper_tb
// Self-checking bench for the RAID 4/5/6 sector mapper. A scoreboard class
// keeps its own copy of the geometry registers and predicts the disk, disk
// sector and P/Q placement of every accepted item. Results are matched in
// order. Directed geometries come first, then random geometries with bursty
// input, a stalling receiver and one long back-pressure hold.
// ----------------------------------------------------------------------------
module raid_stripe_sector_mapper_tb;
  import rssm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 220;
  localparam int LONG_HOLD      = 500;
  localparam int RANDOM_ITEMS   = 700;

  typedef struct packed {
    logic [SECTOR_BITS-1:0] disk_sector;
    logic [DIDX_W-1:0]      data_disk;
    logic [DISK_W-1:0]      parity_disk;
    logic [DISK_W-1:0]      q_parity_disk;
    logic                   bad_layout;
  } mapping_t;

  // Geometry copy, mapping predictor and in-order expected mappings
  class mapping_scoreboard;
    logic [LVL_W-1:0]  level   = LEVEL_5;
    logic [3:0]        lay     = LAY_LEFT_SYM;
    logic [CS_W-1:0]   cs      = CS_W'(128);
    logic [DISK_W-1:0] rd      = DISK_W'(4);
    logic [RED_W-1:0]  red     = RED_W'(1);
    logic [3:0]        old_lay = LAY_LEFT_SYM;
    logic [CS_W-1:0]   old_cs  = CS_W'(128);
    logic [DISK_W-1:0] old_rd  = DISK_W'(4);
    mapping_t          expected_maps[$];
    int                errors  = 0;

    function void write_reg(reg_idx_e idx, logic [CS_W-1:0] val);
      case (idx)
        REG_RAID_LEVEL:     level   = val[LVL_W-1:0];
        REG_LAYOUT:         lay     = val[3:0];
        REG_CHUNK_SIZE:     cs      = val;
        REG_DISK_COUNT:     rd      = val[DISK_W-1:0];
        REG_REDUNDANCY:     red     = val[RED_W-1:0];
        REG_OLD_LAYOUT:     old_lay = val[3:0];
        REG_OLD_CHUNK_SIZE: old_cs  = val;
        REG_OLD_DISK_COUNT: old_rd  = val[DISK_W-1:0];
        default: ;
      endcase
    endfunction

    function mapping_t predict(logic [SECTOR_BITS-1:0] sec, logic use_old);
      mapping_t          m;
      logic [3:0]        alg;
      longint unsigned   c, chunk, stripe, s2, offset;
      longint            n, dd, di, pd, qd;
      alg = use_old ? old_lay : lay;
      c   = use_old ? old_cs : cs;
      n   = use_old ? old_rd : rd;
      m   = '{disk_sector: '0, data_disk: '0, parity_disk: '1, q_parity_disk: '1,
              bad_layout: 1'b1};
      pd  = -1;
      qd  = -1;
      if (c == 0 || n == 0 || n > MAX_DISKS || red > 2) return m;
      dd = n - longint'(red);
      if (dd <= 0) return m;
      offset = sec % c;
      chunk  = sec / c;
      stripe = chunk / longint'(dd);
      di     = longint'(chunk % longint'(dd));
      s2     = stripe;
      if (level == LEVEL_4) begin
        pd = dd;
      end else if (level == LEVEL_5) begin
        case (alg)
          LAY_LEFT_ASYM:  begin pd = dd - longint'(s2 % n); if (di >= pd) di++; end
          LAY_RIGHT_ASYM: begin pd = longint'(s2 % n); if (di >= pd) di++; end
          LAY_LEFT_SYM:   begin pd = dd - longint'(s2 % n); di = (pd + 1 + di) % n; end
          LAY_RIGHT_SYM:  begin pd = longint'(s2 % n); di = (pd + 1 + di) % n; end
          LAY_PARITY_0:   begin pd = 0; di++; end
          LAY_PARITY_N:   pd = dd;
          default: return m;
        endcase
      end else if (level == LEVEL_6) begin
        // "_6" layouts need a spare disk for Q
        if (alg >= LAY_LEFT_ASYM_6 && alg <= LAY_PARITY_0_6 && n < 2) return m;
        case (alg)
          LAY_LEFT_ASYM, LAY_RIGHT_ASYM, LAY_ROT_ZERO_RST, LAY_ROT_N_RST: begin
            if (alg == LAY_ROT_N_RST) s2 += 1;
            if (alg == LAY_LEFT_ASYM || alg == LAY_ROT_N_RST)
              pd = n - 1 - longint'(s2 % n);
            else
              pd = longint'(s2 % n);
            qd = pd + 1;
            if (pd == n - 1) begin
              di++;
              qd = 0;
            end else if (di >= pd) begin
              di += 2;
            end
          end
          LAY_LEFT_SYM, LAY_RIGHT_SYM: begin
            pd = (alg == LAY_LEFT_SYM) ? n - 1 - longint'(s2 % n) : longint'(s2 % n);
            qd = (pd + 1) % n;
            di = (pd + 2 + di) % n;
          end
          LAY_PARITY_0: begin pd = 0; qd = 1; di += 2; end
          LAY_PARITY_N: begin pd = dd; qd = dd + 1; end
          LAY_ROT_N_CONT: begin
            pd = n - 1 - longint'(s2 % n);
            qd = (pd + n - 1) % n;
            di = (pd + 1 + di) % n;
          end
          LAY_LEFT_ASYM_6, LAY_RIGHT_ASYM_6: begin
            pd = (alg == LAY_LEFT_ASYM_6) ? dd - longint'(s2 % (n - 1))
                                          : longint'(s2 % (n - 1));
            if (di >= pd) di++;
            qd = n - 1;
          end
          LAY_LEFT_SYM_6, LAY_RIGHT_SYM_6: begin
            pd = (alg == LAY_LEFT_SYM_6) ? dd - longint'(s2 % (n - 1))
                                         : longint'(s2 % (n - 1));
            di = (pd + 1 + di) % (n - 1);
            qd = n - 1;
          end
          LAY_PARITY_0_6: begin pd = 0; di++; qd = n - 1; end
          default: return m;
        endcase
      end
      m.disk_sector   = SECTOR_BITS'(stripe * c + offset);
      m.data_disk     = DIDX_W'(di);
      m.parity_disk   = DISK_W'(pd);
      m.q_parity_disk = DISK_W'(qd);
      m.bad_layout    = 1'b0;
      return m;
    endfunction

    function void note_item(logic [SECTOR_BITS-1:0] sec, logic use_old);
      expected_maps.push_back(predict(sec, use_old));
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_mapping(mapping_t got);
      mapping_t exp_m;
      if (expected_maps.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      exp_m = expected_maps.pop_front();
      if (got.disk_sector !== exp_m.disk_sector)
        report($sformatf("disk_sector %h exp %h", got.disk_sector, exp_m.disk_sector));
      if (got.data_disk !== exp_m.data_disk)
        report($sformatf("data_disk %0d exp %0d", got.data_disk, exp_m.data_disk));
      if (got.parity_disk !== exp_m.parity_disk)
        report($sformatf("parity_disk %h exp %h", got.parity_disk, exp_m.parity_disk));
      if (got.q_parity_disk !== exp_m.q_parity_disk)
        report($sformatf("q_parity_disk %h exp %h", got.q_parity_disk,
                         exp_m.q_parity_disk));
      if (got.bad_layout !== exp_m.bad_layout)
        report($sformatf("bad_layout %b exp %b", got.bad_layout, exp_m.bad_layout));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [IDX_W-1:0]  cfg_idx_i;
  logic [CS_W-1:0]   cfg_data_i;
  int                items_taken = 0;
  int                idle_cycles = 0;
  mapping_scoreboard sb = new();

  rssm_in_if  in_if ();
  rssm_out_if out_if ();

  raid_stripe_sector_mapper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Handshake monitor: notes inputs, checks outputs, runs the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_item(in_if.array_sector, in_if.use_old);
        items_taken++;
      end
      if (out_if.valid && out_if.ready)
        sb.check_mapping('{out_if.disk_sector, out_if.data_disk, out_if.parity_disk,
                           out_if.q_parity_disk, out_if.bad_layout});
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: stall pattern in one of four randomly drawn modes, one long hold
  initial begin : receiver
    int cyc;
    int mode;
    bit held;
    cyc  = 0;
    mode = 0;
    held = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && items_taken > 300) begin
        held = 1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) == 1);
        2: out_if.ready <= ($urandom_range(0, 7) == 0);
        default: out_if.ready <= (cyc % 5 != 0);
      endcase
      cyc++;
    end
  end

  // Offer one item and hold it until taken
  task automatic send_item(logic [SECTOR_BITS-1:0] sec, logic use_old);
    in_if.valid        <= 1'b1;
    in_if.array_sector <= sec;
    in_if.use_old      <= use_old;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Lower valid and wait until every expected mapping has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_maps.size() != 0) @(posedge clk_i);
  endtask

  // Register write; caller lowers the enable after the last one
  task automatic write_reg(reg_idx_e idx, logic [CS_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic set_geometry(logic [3:0] level, logic [3:0] lay, logic [CS_W-1:0] cs,
                              logic [DISK_W-1:0] rd, logic [RED_W-1:0] red,
                              logic [3:0] old_lay, logic [CS_W-1:0] old_cs,
                              logic [DISK_W-1:0] old_rd);
    drain();
    write_reg(REG_RAID_LEVEL, CS_W'(level));
    write_reg(REG_LAYOUT, CS_W'(lay));
    write_reg(REG_CHUNK_SIZE, cs);
    write_reg(REG_DISK_COUNT, CS_W'(rd));
    write_reg(REG_REDUNDANCY, CS_W'(red));
    write_reg(REG_OLD_LAYOUT, CS_W'(old_lay));
    write_reg(REG_OLD_CHUNK_SIZE, old_cs);
    write_reg(REG_OLD_DISK_COUNT, CS_W'(old_rd));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [SECTOR_BITS-1:0] rand_sector();
    logic [SECTOR_BITS-1:0] s;
    s = SECTOR_BITS'({$urandom(), $urandom()});
    case ($urandom_range(0, 3))
      0: s = s & 48'hFFFFF;
      1: s = s & 48'hFFFFFFFF;
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic [CS_W-1:0] rand_chunk();
    case ($urandom_range(0, 9))
      0: return CS_W'(1);
      1: return CS_W'(1048576);
      2: return '1;
      3: return '0;
      4, 5: return CS_W'($urandom_range(1, 16));
      default: return CS_W'($urandom_range(1, 2097151));
    endcase
  endfunction

  function automatic logic [DISK_W-1:0] rand_disks();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return DISK_W'($urandom_range(65, 127));
      2: return DISK_W'(64);
      3: return DISK_W'(1);
      default: return DISK_W'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic logic [3:0] rand_level();
    case ($urandom_range(0, 9))
      0, 1: return LEVEL_4;
      2, 3, 4: return LEVEL_5;
      5, 6, 7, 8: return LEVEL_6;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [3:0] rand_layout();
    return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(14, 15))
                                       : 4'($urandom_range(0, 13));
  endfunction

  initial begin : stimulus
    int sent;
    int burst;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= REG_RAID_LEVEL;
    cfg_data_i         <= '0;
    in_if.valid        <= 1'b0;
    in_if.array_sector <= '0;
    in_if.use_old      <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry, sector extremes on both geometries
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item('1, 1'b1);
    send_item(48'h123456789A, 1'b1);

    // Level 6, every layout code including unknown ones
    set_geometry(LEVEL_6, LAY_LEFT_SYM, 3, 8, 2, LAY_LEFT_SYM, 5, 7);
    for (int l = 0; l < 16; l++) begin
      drain();
      write_reg(REG_LAYOUT, CS_W'(l));
      cfg_we_i <= 1'b0;
      send_item(rand_sector(), 1'b0);
    end

    // Impossible geometries: zero chunk, zero disks, too many, no data disks
    set_geometry(LEVEL_5, LAY_LEFT_ASYM, 0, 0, 3, LAY_LEFT_ASYM, 2, 100);
    send_item(rand_sector(), 1'b0);
    send_item(rand_sector(), 1'b1);
    set_geometry(LEVEL_5, LAY_LEFT_ASYM, 4, 2, 2, LAY_LEFT_ASYM, 4, 1);
    send_item(rand_sector(), 1'b0);
    send_item(rand_sector(), 1'b1);
    // "_6" layout on a single disk, and a level with no parity
    set_geometry(LEVEL_6, LAY_LEFT_ASYM_6, 1048576, 1, 0, LAY_PARITY_0_6, 1, 64);
    send_item('1, 1'b0);
    send_item('1, 1'b1);
    set_geometry(4'd0, LAY_PARITY_N, 1, 64, 0, LAY_PARITY_N, 2097151, 64);
    send_item('1, 1'b0);
    send_item('1, 1'b1);

    // Random geometries with bursty traffic
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_geometry(rand_level(), rand_layout(), rand_chunk(), rand_disks(),
                   ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                   rand_layout(), rand_chunk(), rand_disks());
      for (int i = 0; i < 50; i++) begin
        send_item(rand_sector(), 1'($urandom_range(0, 1)));
        sent++;
        burst = $urandom_range(0, 15);
        if (burst < 3) begin
          in_if.valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_maps.size() != 0)
      sb.report($sformatf("%0d expected mappings never arrived",
                          sb.expected_maps.size()));
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
